FILE: hdl/evg_pkg.sv
package evg_pkg;

  localparam int unsigned FrameSamplesDef  = 1600;
  localparam int unsigned PrerollFramesDef = 8;

  localparam int unsigned SumW   = 42;
  localparam int unsigned CountW = 11;
  localparam int unsigned SqW    = 31;
  localparam int unsigned FloorW = 24;

  localparam logic [FloorW-1:0] FloorReset = 24'd25600;
  localparam logic [15:0]       ThrMin     = 16'd140;
  localparam logic [17:0]       ThrMax     = 18'd32767;
  localparam logic [7:0]        CountMax   = 8'd255;
  // ceil(2^35 / 10), exact divide by ten for operands below 2^32
  localparam logic [31:0]       RecipTen   = 32'hCCCCCCCD;

  // configuration register indexes
  localparam logic [1:0] RegVadOn     = 2'd0;
  localparam logic [1:0] RegFixedThr  = 2'd1;
  localparam logic [1:0] RegHangover  = 2'd2;
  localparam logic [1:0] RegKeepalive = 2'd3;

  typedef struct packed {
    logic        vad_on;
    logic [14:0] fixed_threshold;
    logic [5:0]  hangover_frames;
    logic [7:0]  keepalive_frames;
  } cfg_t;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] n;
    logic              paused;
  } frame_t;

  typedef struct packed {
    logic [15:0] frame_rms;
    logic [14:0] threshold_used;
    logic        voice;
    logic        send_frame;
    logic [3:0]  flush_count;
    logic [2:0]  flush_head;
    logic        store_frame;
    logic [2:0]  store_slot;
    logic        keepalive_send;
    logic        speech_start;
    logic        speech_end;
  } result_t;

endpackage

FILE: hdl/evg_in_if.sv
interface evg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_end;
  logic               mute_tx;

  modport source (output valid, sample, frame_end, mute_tx, input ready);
  modport sink (input valid, sample, frame_end, mute_tx, output ready);
endinterface

interface evg_out_if;
  import evg_pkg::*;
  logic    valid;
  logic    ready;
  result_t res;

  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

FILE: hdl/evg_front.sv
module evg_front #(
  parameter int unsigned FRAME_SAMPLES = evg_pkg::FrameSamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  evg_in_if.sink          in_i,
  output evg_pkg::frame_t frame_o,
  output logic            push_o,
  input  logic            full_i
);
  import evg_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [SumW-1:0]   sum_q, sum_d, sum_tot;
  logic              s1_v_q, s1_v_d;
  logic [SqW-1:0]    s1_sq_q;
  logic              s1_end_q, s1_paused_q;
  logic [CountW-1:0] s1_n_q;
  logic              s1_adv, accept, is_end;
  logic signed [31:0] sq_full;

  // square stage moves on unless a finished frame finds the queue full
  assign s1_adv     = s1_v_q && !(s1_end_q && full_i);
  assign in_i.ready = !s1_v_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  assign cnt_inc = cnt_q + 1'b1;
  assign is_end  = in_i.frame_end || ({21'd0, cnt_inc} >= FRAME_SAMPLES);
  assign sq_full = in_i.sample * in_i.sample;
  assign sum_tot = sum_q + {{(SumW-SqW){1'b0}}, s1_sq_q};

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    s1_v_d = s1_v_q;
    if (s1_adv) begin
      sum_d  = s1_end_q ? '0 : sum_tot;
      s1_v_d = 1'b0;
    end
    if (accept) begin
      cnt_d  = is_end ? '0 : cnt_inc;
      s1_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      s1_v_q <= s1_v_d;
    end
  end

  // hold the squared sample with its frame marks
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sq_q     <= sq_full[SqW-1:0];
      s1_end_q    <= is_end;
      s1_paused_q <= in_i.mute_tx;
      s1_n_q      <= cnt_inc;
    end
  end

  assign push_o         = s1_adv && s1_end_q;
  assign frame_o.sum    = sum_tot;
  assign frame_o.n      = s1_n_q;
  assign frame_o.paused = s1_paused_q;
endmodule

FILE: hdl/evg_fifo.sv
module evg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  evg_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output evg_pkg::frame_t data_o,
  output logic            empty_o
);
  import evg_pkg::*;

  frame_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

FILE: hdl/evg_back.sv
module evg_back #(
  parameter int unsigned PREROLL_FRAMES = evg_pkg::PrerollFramesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  evg_pkg::cfg_t   cfg_i,
  input  evg_pkg::frame_t frame_i,
  input  logic            empty_i,
  output logic            pop_o,
  evg_out_if.source       out_o
);
  import evg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DEC  = 5'b10000
  } state_e;

  localparam logic [3:0] Depth = 4'(PREROLL_FRAMES);

  state_e            state_q, state_d;
  logic [5:0]        step_q, step_d;
  logic [SumW-1:0]   dvd_q, dvd_d;
  logic [CountW:0]   drem_q, drem_d;
  logic [CountW-1:0] n_q;
  logic              paused_q;
  logic [31:0]       sx_q, sx_d;
  logic [19:0]       srem_q, srem_d;
  logic [15:0]       root_q, root_d;
  logic              loud_q;
  logic [59:0]       prod_q;

  logic [FloorW-1:0] floor_q, floor_d;
  logic              speech_q, speech_d;
  logic [5:0]        hang_q, hang_d;
  logic [3:0]        fill_q, fill_d;
  logic [2:0]        head_q, head_d;
  logic [7:0]        ka_q, ka_d;
  logic              ov_q, ov_d;
  result_t           res_q, res_d;
  logic              emit;

  // divide and root step arithmetic
  logic [CountW+1:0] dr;
  logic              dge;
  logic [19:0]       sr, st;
  logic              sge;
  logic [26:0]       floor5;
  logic [27:0]       num;
  logic [FloorW-1:0] nf;
  logic [26:0]       nf5;
  logic [17:0]       thr_w;
  logic [14:0]       thr;
  logic              voice;
  logic [3:0]        slot_sum;

  assign dr  = {drem_q, dvd_q[SumW-1]};
  assign dge = dr >= {2'b00, n_q};
  assign sr  = {srem_q[17:0], sx_q[31:30]};
  assign st  = {2'b00, root_q, 2'b01};
  assign sge = sr >= st;
  assign floor5 = {1'b0, floor_q, 2'b00} + {3'b000, floor_q};

  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign emit  = (state_q == ST_DEC) && (!ov_q || out_o.ready);

  // sequence divide, root, floor product and decision
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    drem_d  = drem_q;
    sx_d    = sx_q;
    srem_d  = srem_q;
    root_d  = root_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          dvd_d   = frame_i.sum;
          drem_d  = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        drem_d = dge ? (CountW+1)'(dr - {2'b00, n_q}) : dr[CountW:0];
        dvd_d  = {dvd_q[SumW-2:0], dge};
        step_d = step_q + 1'b1;
        if (step_q == 6'(SumW - 1)) begin
          sx_d    = dvd_d[31:0];
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_d = sge ? sr - st : sr;
        root_d = {root_q[14:0], sge};
        sx_d   = {sx_q[29:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == 6'd15) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_DEC;
      ST_DEC: begin
        if (emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // adapt the floor and make the frame decision
  always_comb begin
    num = {1'b0, floor_q, 3'b000} + {4'd0, floor_q} + {4'd0, root_q, 8'd0};
    if (cfg_i.fixed_threshold != '0) begin
      nf  = floor_q;
      nf5 = '0;
      thr_w = '0;
      thr = cfg_i.fixed_threshold;
    end else begin
      nf  = loud_q ? floor_q : prod_q[35+:FloorW];
      nf5 = {1'b0, nf, 2'b00} + {3'b000, nf};
      thr_w = nf5[26:9];
      if (thr_w < {2'b00, ThrMin}) thr = ThrMin[14:0];
      else if (thr_w > ThrMax) thr = ThrMax[14:0];
      else thr = thr_w[14:0];
    end
    voice = root_q >= {1'b0, thr};

    floor_d  = floor_q;
    speech_d = speech_q;
    hang_d   = hang_q;
    fill_d   = fill_q;
    head_d   = head_q;
    ka_d     = ka_q;
    res_d    = '0;
    slot_sum = {1'b0, head_q} + fill_q;

    res_d.frame_rms      = root_q;
    res_d.threshold_used = thr;
    res_d.voice          = voice;

    if (emit) begin
      floor_d = nf;
      if (cfg_i.vad_on) begin
        if (voice) begin
          if (!speech_q) begin
            res_d.flush_count  = fill_q;
            res_d.flush_head   = head_q;
            fill_d             = '0;
            head_d             = '0;
            speech_d           = 1'b1;
            res_d.speech_start = 1'b1;
          end
          hang_d           = cfg_i.hangover_frames;
          res_d.send_frame = 1'b1;
        end else if (speech_q && hang_q != '0) begin
          hang_d           = hang_q - 1'b1;
          res_d.send_frame = 1'b1;
          if (hang_q == 6'd1) begin
            speech_d         = 1'b0;
            res_d.speech_end = 1'b1;
          end
        end else begin
          speech_d          = 1'b0;
          res_d.store_frame = 1'b1;
          if (fill_q < Depth) begin
            res_d.store_slot = (slot_sum >= Depth) ? 3'(slot_sum - Depth) : slot_sum[2:0];
            fill_d = fill_q + 1'b1;
          end else begin
            res_d.store_slot = head_q;
            head_d = ({1'b0, head_q} + 4'd1 >= Depth) ? 3'(4'(head_q) + 4'd1 - Depth)
                                                       : head_q + 3'd1;
          end
        end
      end else begin
        res_d.send_frame = 1'b1;
      end

      // keepalive uses the speech flag after its update
      if (!voice && !speech_d && ka_q >= cfg_i.keepalive_frames) begin
        res_d.keepalive_send = 1'b1;
        ka_d = 8'd1;
      end else if (ka_q < CountMax) begin
        ka_d = ka_q + 1'b1;
      end

      if (paused_q) begin
        res_d.send_frame     = 1'b0;
        res_d.keepalive_send = 1'b0;
        res_d.flush_count    = '0;
      end
      if (res_d.flush_count == '0) res_d.flush_head = '0;
    end
  end

  assign ov_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      floor_q  <= FloorReset;
      speech_q <= 1'b0;
      hang_q   <= '0;
      fill_q   <= '0;
      head_q   <= '0;
      ka_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      floor_q  <= floor_d;
      speech_q <= speech_d;
      hang_q   <= hang_d;
      fill_q   <= fill_d;
      head_q   <= head_d;
      ka_q     <= ka_d;
      ov_q     <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    drem_q <= drem_d;
    sx_q   <= sx_d;
    srem_q <= srem_d;
    root_q <= root_d;
    if (pop_o) begin
      n_q      <= frame_i.n;
      paused_q <= frame_i.paused;
    end
    if (state_q == ST_MUL) begin
      loud_q <= ({root_q, 9'd0} > {1'b0, floor5}) && (root_q > ThrMin);
      prod_q <= num * RecipTen;
    end
    if (emit) res_q <= res_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.res   = res_q;
endmodule

FILE: hdl/energy_vad_gate_with_preroll_unit.sv
// Energy voice gate with hangover and pre-roll. Samples enter on in_i, one
// per cycle while in_i.ready is high; each frame (frame_end, or FRAME_SAMPLES
// samples) yields one descriptor on out_o after the bit-serial mean divider,
// the root iteration, then floor update and decision. The back end works on
// one frame at a time, and a two-entry frame queue lets the next frame's
// samples flow meanwhile, so frames of at least 61 samples run without input
// stalls while out_o is ready.
// Configuration writes are taken whenever cfg_we_i is high and must only be
// issued while the block is idle.
module energy_vad_gate_with_preroll_unit #(
  parameter int unsigned FRAME_SAMPLES  = evg_pkg::FrameSamplesDef,
  parameter int unsigned PREROLL_FRAMES = evg_pkg::PrerollFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  evg_in_if.sink      in_i,
  evg_out_if.source   out_o
);
  import evg_pkg::*;

  cfg_t   cfg_q;
  frame_t f_push, f_pop;
  logic   push, full, pop, empty;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vad_on           <= 1'b1;
      cfg_q.fixed_threshold  <= '0;
      cfg_q.hangover_frames  <= 6'd30;
      cfg_q.keepalive_frames <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVadOn:     cfg_q.vad_on           <= cfg_data_i[0];
        RegFixedThr:  cfg_q.fixed_threshold  <= cfg_data_i;
        RegHangover:  cfg_q.hangover_frames  <= cfg_data_i[5:0];
        RegKeepalive: cfg_q.keepalive_frames <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  evg_front #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_front (
    .clk_i, .rst_ni, .in_i, .frame_o(f_push), .push_o(push), .full_i(full)
  );

  evg_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_push), .full_o(full),
    .pop_i(pop), .data_o(f_pop), .empty_o(empty)
  );

  evg_back #(.PREROLL_FRAMES(PREROLL_FRAMES)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .frame_i(f_pop), .empty_i(empty),
    .pop_o(pop), .out_o
  );
endmodule
